// ===== hdl/tww_pkg.sv =====
// shared types and constants for the text width and wrap finder
// used by every module of the block except tww_ram; depends on nothing
package tww_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_FONT_SIZE   = 2'd0,
    CFG_SIZE_RATIO  = 2'd1,
    CFG_WIDTH_LIMIT = 2'd2
  } cfg_idx_e;

  localparam int unsigned FontSizeW   = 10;
  localparam int unsigned RatioW      = 16;
  localparam int unsigned LimitW      = 24;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CodeW       = 8;
  localparam int unsigned GlyphW      = 16;
  localparam int unsigned ProductW    = 33;
  localparam int unsigned AccW        = 40;
  localparam int unsigned LineWidthW  = 16;
  localparam int unsigned BreakIndexW = 12;

  localparam logic [FontSizeW-1:0] FontSizeRst   = 10'd16;
  localparam logic [RatioW-1:0]    SizeRatioRst  = 16'd256;
  localparam logic [LimitW-1:0]    WidthLimitRst = 24'd163840;

  localparam logic [CodeW-1:0] CharQuestion = 8'd63;
  localparam logic [CodeW-1:0] CharSpace    = 8'd32;

  typedef struct packed {
    logic [FontSizeW-1:0] font_size;
    logic [RatioW-1:0]    size_ratio;
    logic [LimitW-1:0]    width_limit;
  } cfg_t;

  // one scaled advance on its way to the accumulator
  typedef struct packed {
    logic                       valid;
    logic signed [ProductW-1:0] product;
    logic                       is_space;
    logic                       last;
  } scaled_t;

endpackage

// ===== hdl/tww_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependency
module tww_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tww_glyph_scale.sv =====
// glyph table, missing-glyph substitution and advance scaling
// depends on tww_pkg and tww_ram
module tww_glyph_scale #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tww_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_opcode_i,
  input  logic [tww_pkg::CodeW-1:0]       in_char_code_i,
  input  logic signed [tww_pkg::GlyphW-1:0] in_glyph_advance_i,
  input  logic signed [tww_pkg::GlyphW-1:0] in_glyph_baseline_i,
  input  logic                            in_last_char_i,
  input  logic                            take_i,
  output tww_pkg::scaled_t                scaled_o
);
  import tww_pkg::*;

  localparam int unsigned AddrW = $clog2(GLYPH_COUNT);

  logic                   en1, en2, accept, text_acc, load_we, in_range;
  logic [2*GlyphW-1:0]    rdata;
  logic [GlyphW-1:0]      q_adv_q;
  logic                   s1_valid_q, s1_last_q, s1_in_range_q;
  logic [CodeW-1:0]       s1_code_q;
  logic [GlyphW:0]        neg_font;
  logic [GlyphW-1:0]      rd_adv, rd_base;
  logic                   missing;
  logic signed [GlyphW-1:0] adv;
  logic signed [RatioW:0] ratio_s;
  logic signed [ProductW-1:0] product;
  logic                   s2_valid_q, s2_space_q, s2_last_q;
  logic signed [ProductW-1:0] s2_product_q;

  assign en2        = !s2_valid_q || take_i;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign in_range   = {1'b0, in_char_code_i} < 9'(GLYPH_COUNT);
  assign text_acc   = accept && (in_opcode_i == OP_TEXT);
  assign load_we    = accept && (in_opcode_i == OP_LOAD) && in_range;

  // baseline in the upper half, advance in the lower half
  tww_ram #(
    .Width(2 * GlyphW),
    .Depth(GLYPH_COUNT)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(in_char_code_i[AddrW-1:0]),
    .wdata_i({in_glyph_baseline_i, in_glyph_advance_i}),
    .re_i   (text_acc),
    .raddr_i(in_char_code_i[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_adv_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (load_we && in_char_code_i == CharQuestion) begin
        q_adv_q <= in_glyph_advance_i;
      end
      if (en1) begin
        s1_valid_q <= text_acc;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_acc) begin
      s1_code_q     <= in_char_code_i;
      s1_last_q     <= in_last_char_i;
      s1_in_range_q <= in_range;
    end
    if (en2 && s1_valid_q) begin
      s2_product_q <= product;
      s2_space_q   <= !missing && (s1_code_q == CharSpace);
      s2_last_q    <= s1_last_q;
    end
  end

  always_comb begin
    rd_adv   = rdata[GlyphW-1:0];
    rd_base  = rdata[2*GlyphW-1:GlyphW];
    neg_font = (GlyphW+1)'(0) - (GlyphW+1)'(cfg_i.font_size);
    // missing glyph when the code is out of range or the baseline sits at minus the font size
    missing  = !s1_in_range_q || ({rd_base[GlyphW-1], rd_base} == neg_font);
    adv      = missing ? $signed(q_adv_q) : $signed(rd_adv);
    ratio_s  = $signed({1'b0, cfg_i.size_ratio});
    product  = adv * ratio_s;
  end

  assign scaled_o = {s2_valid_q, s2_product_q, s2_space_q, s2_last_q};

endmodule

// ===== hdl/tww_line_accum.sv =====
// running width accumulator, break finder and result register
// depends on tww_pkg
module tww_line_accum #(
  parameter int unsigned MAX_TEXT = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tww_pkg::cfg_t                       cfg_i,
  input  tww_pkg::scaled_t                    scaled_i,
  output logic                                take_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tww_pkg::LineWidthW-1:0]      out_line_width_o,
  output logic                                out_break_found_o,
  output logic [tww_pkg::BreakIndexW-1:0]     out_break_index_o,
  output logic                                out_text_end_o
);
  import tww_pkg::*;

  localparam int unsigned IndexCap = (MAX_TEXT - 1 < 4095) ? MAX_TEXT - 1 : 4095;
  localparam int unsigned IdxW     = $clog2(IndexCap + 1);

  logic                   consume;
  logic signed [AccW-1:0] acc_q, acc_new;
  logic [AccW:0]          sum;
  logic [IdxW-1:0]        char_idx_q, space_idx_q, brk_pos_q, brk_pos_new, char_idx_new;
  logic [IdxW:0]          space_next;
  logic                   space_seen_q, brk_q, over, brk_new;
  logic [LineWidthW-1:0]  lw;
  logic                   out_valid_q, found_q, end_q;
  logic [LineWidthW-1:0]  lw_q;
  logic [BreakIndexW-1:0] bidx_q;

  assign take_o  = !out_valid_q || !out_stall_i;
  assign consume = scaled_i.valid && take_o;

  always_comb begin
    sum = {acc_q[AccW-1], acc_q} + (AccW+1)'(scaled_i.product);
    // saturate to the signed accumulator range
    if (sum[AccW] != sum[AccW-1]) begin
      acc_new = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_new = sum[AccW-1:0];
    end
    over       = !acc_new[AccW-1] && (acc_new[AccW-2:0] > (AccW-1)'(cfg_i.width_limit));
    brk_new    = brk_q || over;
    space_next = {1'b0, space_idx_q} + (IdxW+1)'(1);
    brk_pos_new = brk_pos_q;
    if (!brk_q && over) begin
      if (!space_seen_q) begin
        brk_pos_new = '0;
      end else if (space_next > (IdxW+1)'(IndexCap)) begin
        brk_pos_new = IdxW'(IndexCap);
      end else begin
        brk_pos_new = space_next[IdxW-1:0];
      end
    end
    char_idx_new = (char_idx_q < IdxW'(IndexCap)) ? char_idx_q + IdxW'(1) : char_idx_q;
    if (acc_new[AccW-1]) begin
      lw = '0;
    end else if (|acc_new[AccW-2:LineWidthW+8]) begin
      lw = '1;
    end else begin
      lw = acc_new[LineWidthW+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      char_idx_q   <= '0;
      space_idx_q  <= '0;
      space_seen_q <= 1'b0;
      brk_q        <= 1'b0;
      brk_pos_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_o) begin
        out_valid_q <= scaled_i.valid;
      end
      if (consume) begin
        if (scaled_i.last) begin
          acc_q        <= '0;
          char_idx_q   <= '0;
          space_idx_q  <= '0;
          space_seen_q <= 1'b0;
          brk_q        <= 1'b0;
          brk_pos_q    <= '0;
        end else begin
          acc_q      <= acc_new;
          char_idx_q <= char_idx_new;
          brk_q      <= brk_new;
          brk_pos_q  <= brk_pos_new;
          if (scaled_i.is_space) begin
            space_idx_q  <= char_idx_q;
            space_seen_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      lw_q    <= lw;
      found_q <= brk_new;
      bidx_q  <= brk_new ? BreakIndexW'(brk_pos_new) : '0;
      end_q   <= scaled_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_line_width_o  = lw_q;
  assign out_break_found_o = found_q;
  assign out_break_index_o = bidx_q;
  assign out_text_end_o    = end_q;

endmodule

// ===== hdl/text_width_and_wrap_finder.sv =====
// top level of the text width and greedy word-wrap break finder
// depends on tww_pkg, tww_glyph_scale, tww_line_accum
//
// Load items (opcode 0) write one glyph's advance and baseline into a table of
// GLYPH_COUNT entries and produce no result. Text items (opcode 1) produce one
// result each: the saturated integer line width, the latched break flag and the
// start index of the next line; the item marked last closes the string and
// resets the line state. One item is accepted per clock while the input is not
// stalled; a text byte's result passes the table read, scaling multiply and
// accumulate registers in that order, and the combinational add/saturate/compare
// loop of the accumulator is what sets the one-item-per-cycle rate. The input
// stalls only when every stage up to a held result is occupied. The configuration
// port is always ready; write it only while no text byte is in flight.
module text_width_and_wrap_finder #(
  parameter int unsigned GLYPH_COUNT = 256,
  parameter int unsigned MAX_TEXT    = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tww_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [tww_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  in_opcode_i,
  input  logic [tww_pkg::CodeW-1:0]             in_char_code_i,
  input  logic signed [tww_pkg::GlyphW-1:0]     in_glyph_advance_i,
  input  logic signed [tww_pkg::GlyphW-1:0]     in_glyph_baseline_i,
  input  logic                                  in_last_char_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tww_pkg::LineWidthW-1:0]        out_line_width_o,
  output logic                                  out_break_found_o,
  output logic [tww_pkg::BreakIndexW-1:0]       out_break_index_o,
  output logic                                  out_text_end_o
);
  import tww_pkg::*;

  cfg_t    cfg_q;
  scaled_t scaled;
  logic    take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_size   <= FontSizeRst;
      cfg_q.size_ratio  <= SizeRatioRst;
      cfg_q.width_limit <= WidthLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FONT_SIZE:   cfg_q.font_size   <= cfg_data_i[FontSizeW-1:0];
        CFG_SIZE_RATIO:  cfg_q.size_ratio  <= cfg_data_i[RatioW-1:0];
        CFG_WIDTH_LIMIT: cfg_q.width_limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  tww_glyph_scale #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_glyph_scale (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_char_code_i     (in_char_code_i),
    .in_glyph_advance_i (in_glyph_advance_i),
    .in_glyph_baseline_i(in_glyph_baseline_i),
    .in_last_char_i     (in_last_char_i),
    .take_i             (take),
    .scaled_o           (scaled)
  );

  tww_line_accum #(
    .MAX_TEXT(MAX_TEXT)
  ) u_line_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .scaled_i         (scaled),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_line_width_o (out_line_width_o),
    .out_break_found_o(out_break_found_o),
    .out_break_index_o(out_break_index_o),
    .out_text_end_o   (out_text_end_o)
  );

endmodule

// ===== hdl/tww_checker.sv =====
// port-level checks for the text width and wrap finder, bound to the top level
// depends on tww_pkg
module tww_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_valid_i,
  input logic                                  cfg_ready_o,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  in_opcode_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [tww_pkg::LineWidthW-1:0]        out_line_width_o,
  input logic                                  out_break_found_o,
  input logic [tww_pkg::BreakIndexW-1:0]       out_break_index_o,
  input logic                                  out_text_end_o
);
  import tww_pkg::*;

  logic text_xfer;
  assign text_xfer = in_valid_i && !in_stall_o && (in_opcode_i == OP_TEXT);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_line_width_o)
      && $stable(out_break_found_o) && $stable(out_break_index_o)
      && $stable(out_text_end_o))
    else $error("result changed while stalled");

  // no break position without a latched break
  a_index_needs_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_break_found_o |-> out_break_index_o == '0)
    else $error("break index set without break");

  // a text byte reaches the output through the table read, scaling and accumulate registers when the output drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(text_xfer, 3) && $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3)
      && $past(!out_stall_i, 1) && $past(!out_stall_i, 2) |-> out_valid_o)
    else $error("text byte result missing");

  // configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind text_width_and_wrap_finder tww_checker u_tww_checker (.*);
